[hw/rtl/hdec_pkg.sv]
// Shared types and constants for the Huffman tree bit decoder.
// No dependencies; imported by every module of the block.
package hdec_pkg;

    localparam int unsigned IDX_W  = 9;
    localparam int unsigned SYM_W  = 8;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned BCNT_W = 4;

    localparam logic [BCNT_W-1:0] BITS_PER_CODE = 4'd8;
    localparam logic              CMD_WRITE     = 1'b0;
    localparam logic              CMD_DECODE    = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [SYM_W-1:0] sym;
    } node_entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        node_entry_t      data;
    } node_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } node_rd_t;

    typedef struct packed {
        logic             load;
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             finished;
    } emit_t;

endpackage

[hw/rtl/hdec_node_mem.sv]
// Node table: one write port and one registered read port.
// Depends on hdec_pkg.
module hdec_node_mem
    import hdec_pkg::*;
#(
    parameter int unsigned NODE_SLOTS = 511
)
(
    input  logic        clk,
    input  node_wr_t    wr,
    input  node_rd_t    rd,
    output node_entry_t rdata
);

    localparam int unsigned AW = $clog2(NODE_SLOTS);

    node_entry_t mem [NODE_SLOTS];
    node_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/hdec_seq.sv]
// Bit-walk sequencer: steps the tree one code bit at a time through the node table,
// holds one pending symbol so the last flag of a code byte can be set. Depends on hdec_pkg.
module hdec_seq
    import hdec_pkg::*;
#(
    parameter int unsigned NODE_SLOTS = 511
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              cmd,
    input  logic [IDX_W-1:0]  node_index,
    input  logic [IDX_W-1:0]  left_child,
    input  logic [IDX_W-1:0]  right_child,
    input  logic [SYM_W-1:0]  leaf_symbol,
    input  logic [CODE_W-1:0] code_byte,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic              out_free,
    input  node_entry_t       rdata,
    output logic              busy,
    output node_wr_t          mem_wr,
    output node_rd_t          mem_rd,
    output emit_t             emit
);

    localparam logic [IDX_W-1:0] SLOTS = IDX_W'(NODE_SLOTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]  pend_sym_reg, pend_sym_next;
    logic              pend_fin_reg, pend_fin_next;

    logic [IDX_W-1:0]  child;
    logic              is_leaf;

    // Code bit is the MSB of the shift register
    assign child   = code_reg[CODE_W-1] ? rdata.right : rdata.left;
    assign is_leaf = (rdata.left >= SLOTS) && (rdata.right >= SLOTS);
    assign busy    = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        remain_next     = remain_reg;
        code_next       = code_reg;
        bcnt_next       = bcnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_fin_next   = pend_fin_reg;

        mem_wr.en   = 1'b0;
        mem_wr.addr = node_index;
        mem_wr.data = '{left: left_child, right: right_child, sym: leaf_symbol};
        mem_rd.en   = 1'b0;
        mem_rd.addr = cur_reg;
        emit.load     = 1'b0;
        emit.sym      = pend_sym_reg;
        emit.last     = 1'b0;
        emit.finished = pend_fin_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    remain_next = cfg_wdata;
                    cur_next    = '0;
                end
                else if (in_fire)
                begin
                    if (cmd == CMD_WRITE)
                    begin
                        mem_wr.en = (node_index < SLOTS);
                    end
                    else if (remain_reg != '0)
                    begin
                        code_next  = code_byte;
                        bcnt_next  = '0;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                mem_rd.en  = 1'b1;
                mem_rd.addr = cur_reg;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (bcnt_reg == BITS_PER_CODE)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    code_next = {code_reg[CODE_W-2:0], 1'b0};
                    bcnt_next = bcnt_reg + 1'b1;
                    // Missing child: drop the bit and stay on this node
                    if (child < SLOTS)
                    begin
                        cur_next    = child;
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = child;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (!is_leaf)
                begin
                    state_next = S_STEP;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // Hand the older symbol to the output, keep the new one pending
                    emit.load       = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_sym_next   = rdata.sym;
                    pend_fin_next   = (remain_reg == CNT_W'(1));
                    remain_next     = remain_reg - 1'b1;
                    cur_next        = '0;
                    if (remain_reg == CNT_W'(1) || bcnt_reg == BITS_PER_CODE)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = '0;
                        state_next  = S_STEP;
                    end
                end
            end
            S_FLUSH:
            begin
                emit.last = 1'b1;
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    emit.load       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            remain_reg     <= '0;
            bcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            remain_reg     <= remain_next;
            bcnt_reg       <= bcnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        pend_sym_reg <= pend_sym_next;
        pend_fin_reg <= pend_fin_next;
    end

endmodule

[hw/rtl/huffman_tree_bit_decoder_core.sv]
// Top level of the Huffman tree bit decoder: input handshake, output register.
// Depends on hdec_pkg, hdec_node_mem and hdec_seq.
//
// Walks a Huffman code tree held in an on-chip node table of NODE_SLOTS entries
// (root at slot 0). An input beat with cmd = 0 writes one node (left child, right
// child, leaf symbol; a child of NODE_SLOTS or more, 511 included, means none). A
// beat with cmd = 1 decodes one code byte, MSB first: a 0 bit goes left, a 1 bit
// goes right, a bit with no child is dropped, and reaching a node with no children
// emits its symbol and returns to the root. A code byte first fetches the current
// node in S_FETCH. After that, a bit with no child is dropped in S_STEP, and a bit
// that steps to a child passes through S_STEP and then S_CHECK, which checks the
// fetched child. A leaf refetches the root within that S_CHECK. One more S_STEP
// closes the byte unless its last bit hit a leaf, and S_FLUSH flushes its last
// symbol. The input stays stalled from the accepting edge until the walk is back in
// S_IDLE. The stall ends early when the count runs out inside the byte, and it grows
// whenever the output side stalls. The node table read port paces the walk, since
// each bit needs the node fetched by the previous one. A byte gives up to 8 output
// beats; last marks its final symbol, and finished marks the symbol that brings the
// remaining count to zero, after which code bytes give nothing until total_symbols
// is written again through cfg_we / cfg_wdata (which also returns the walk to the
// root). Write configuration only while the block is idle. The node table has no
// reset: decode only over written nodes. The output register lets the next symbol
// be found while the previous one waits on out_stall.
module huffman_tree_bit_decoder_core
    import hdec_pkg::*;
#(
    parameter int unsigned NODE_SLOTS = 511
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [IDX_W-1:0]  node_index,
    input  logic [IDX_W-1:0]  left_child,
    input  logic [IDX_W-1:0]  right_child,
    input  logic [SYM_W-1:0]  leaf_symbol,
    input  logic [CODE_W-1:0] code_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SYM_W-1:0]  symbol,
    output logic              last,
    output logic              finished,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata
);

    node_wr_t    mem_wr;
    node_rd_t    mem_rd;
    node_entry_t rdata;
    emit_t       emit;
    logic        busy;
    logic        in_fire;
    logic        out_free;

    logic             out_valid_reg;
    logic [SYM_W-1:0] symbol_reg;
    logic             last_reg;
    logic             finished_reg;

    // Hold the input while a code byte is being walked
    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;
    // The output register can take a new symbol if empty or drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    hdec_node_mem #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .rd    (mem_rd),
        .rdata (rdata)
    );

    hdec_seq #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .cmd         (cmd),
        .node_index  (node_index),
        .left_child  (left_child),
        .right_child (right_child),
        .leaf_symbol (leaf_symbol),
        .code_byte   (code_byte),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_free    (out_free),
        .rdata       (rdata),
        .busy        (busy),
        .mem_wr      (mem_wr),
        .mem_rd      (mem_rd),
        .emit        (emit)
    );

    // Output register: load on emit, drop valid once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            symbol_reg   <= emit.sym;
            last_reg     <= emit.last;
            finished_reg <= emit.finished;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;
    assign finished  = finished_reg;

endmodule

[hw/rtl/hdec_checker.sv]
// Port-level checks for the Huffman tree bit decoder, bound to the top level.
// Depends on hdec_pkg and huffman_tree_bit_decoder_core.
module hdec_checker
    import hdec_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             cmd,
    input logic             out_valid,
    input logic             out_stall,
    input logic [SYM_W-1:0] symbol,
    input logic             last,
    input logic             finished
);

    // A stalled output beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(symbol) && $stable(last) && $stable(finished))
        else $error("output payload changed while stalled");

    // The symbol that exhausts the count always closes its code byte
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> last)
        else $error("finished without last");

    // A node write leaves the block ready
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_WRITE |=> !in_stall)
        else $error("node write held the input");

    // Nothing follows the finishing symbol in the very next cycle
    a_fin_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && finished |=> !out_valid)
        else $error("output beat right after finished");

endmodule

bind huffman_tree_bit_decoder_core hdec_checker u_hdec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last),
    .finished  (finished)
);
